>>> rtl/indexed_list_insert_delete_top_macros.svh
// Assertion macros for the indexed list block.
// Included by indexed_list_insert_delete_top; needs aclk and aresetn in scope.
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ILID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define ILID_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

>>> rtl/ilid_pkg.sv
// Types, sizes and operation/status codes for the indexed list block.
// No dependencies.
package ilid_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_BITS  = 32;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int POS_BITS   = $clog2(DEPTH);
    localparam int IN_POS_BITS  = 5;
    localparam int IN_VAL_BITS  = 32;
    localparam int OUT_VAL_BITS = 32;
    localparam int OUT_CNT_BITS = 5;
    localparam int S_DATA_BITS  = ((IN_POS_BITS + IN_VAL_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((OUT_VAL_BITS + OUT_CNT_BITS + 7) / 8) * 8;

    typedef logic [1:0]           mode_t;
    typedef logic [1:0]           status_t;
    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam mode_t OP_APPEND = 2'd0;
    localparam mode_t OP_INSERT = 2'd1;
    localparam mode_t OP_DELETE = 2'd2;
    localparam mode_t OP_READ   = 2'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

>>> rtl/indexed_list_insert_delete_top.sv
// Indexed list with append, insert, delete and read at a position.
// Uses ilid_pkg and the assertion macros in indexed_list_insert_delete_top_macros.svh.
//
// Usage:
//   Input stream (s_*): one operation per transfer. s_tuser carries the
//   operation code, s_tdata the position and the word to store.
//   Result stream (m_*): exactly one result per operation, in order.
//   m_tuser carries the status, m_tdata the word read and the entry count.
//   An operation is held in the input register, loaded at the transfer edge,
//   and its result in the result register, loaded once the result side is free.
//   Throughput: one operation per cycle while m_tready is high; every
//   entry shifts in the same cycle through its own select, so an operation
//   sees all earlier ones completed.
//   Reset (aresetn low, synchronous): the list becomes empty and both
//   pipeline registers are emptied; stored words are left as they are.
//   Stall: when m_tready is low the result is held, the input register
//   holds its operation and s_tready drops once both registers are full.
//   Failed operations (bad position, full list) change nothing.
`include "indexed_list_insert_delete_top_macros.svh"

module indexed_list_insert_delete_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [4:0] position, [36:5] value_in, upper bits zero
    input  logic [ilid_pkg::S_DATA_BITS-1:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] value_out, [36:32] entry_count, upper bits zero
    output logic [ilid_pkg::M_DATA_BITS-1:0] m_tdata,
    // [1:0] status
    output logic [1:0]                       m_tuser
);
    import ilid_pkg::*;

    // Input register
    logic                   in_vld_reg;
    mode_t                  in_mode_reg;
    logic [IN_POS_BITS-1:0] in_pos_reg;
    word_t                  in_word_reg;

    // List state
    word_t entries_reg  [DEPTH];
    word_t entries_next [DEPTH];
    cnt_t  count_reg, count_next;

    // Result register
    logic                    out_vld_reg;
    status_t                 out_status_reg, out_status_next;
    word_t                   out_word_reg, out_word_next;
    cnt_t                    out_count_reg;

    logic       adv;
    logic       pos_le_cnt, pos_lt_cnt, full;
    logic [POS_BITS-1:0] pos_idx;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_mode_reg <= mode_t'(s_tuser);
            in_pos_reg  <= s_tdata[IN_POS_BITS-1:0];
            in_word_reg <= word_t'(s_tdata[IN_POS_BITS +: IN_VAL_BITS]);
        end
    end

    assign pos_le_cnt = {1'b0, in_pos_reg} <= {1'b0, cnt_t'(count_reg)};
    assign pos_lt_cnt = {1'b0, in_pos_reg} <  {1'b0, cnt_t'(count_reg)};
    assign full       = count_reg >= cnt_t'(DEPTH);
    assign pos_idx    = in_pos_reg[POS_BITS-1:0];

    always_comb begin
        logic do_append, do_insert, do_delete;
        do_append       = 1'b0;
        do_insert       = 1'b0;
        do_delete       = 1'b0;
        out_status_next = ST_DONE;
        out_word_next   = '0;
        count_next      = count_reg;
        case (in_mode_reg)
            OP_APPEND: begin
                if (full) out_status_next = ST_FULL;
                else      do_append = 1'b1;
            end
            OP_INSERT: begin
                if (!pos_le_cnt) out_status_next = ST_RANGE;
                else if (full)   out_status_next = ST_FULL;
                else             do_insert = 1'b1;
            end
            OP_DELETE: begin
                if (!pos_lt_cnt) out_status_next = ST_RANGE;
                else             do_delete = 1'b1;
            end
            OP_READ: begin
                if (!pos_lt_cnt) out_status_next = ST_RANGE;
                else             out_word_next = entries_reg[pos_idx];
            end
            default: out_status_next = ST_RANGE;
        endcase
        if (do_append || do_insert) count_next = count_reg + cnt_t'(1);
        if (do_delete)              count_next = count_reg - cnt_t'(1);

        for (int i = 0; i < DEPTH; i++) begin
            entries_next[i] = entries_reg[i];
            if (do_append && cnt_t'(i) == count_reg) begin
                entries_next[i] = in_word_reg;
            end
            if (do_insert) begin
                if (cnt_t'(i) == cnt_t'(in_pos_reg)) begin
                    entries_next[i] = in_word_reg;
                end else if (i > 0 && cnt_t'(i) > cnt_t'(in_pos_reg)
                             && cnt_t'(i) <= count_reg) begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            // Close the gap: pull the following entry down
            if (do_delete && i < DEPTH - 1 && cnt_t'(i) >= cnt_t'(in_pos_reg)
                && cnt_t'(i + 1) < count_reg) begin
                entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg) count_reg <= count_next;
        end
        if (adv && in_vld_reg) begin
            for (int i = 0; i < DEPTH; i++) entries_reg[i] <= entries_next[i];
            out_status_reg <= out_status_next;
            out_word_reg   <= out_word_next;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_DATA_BITS - OUT_VAL_BITS - OUT_CNT_BITS){1'b0}},
                       OUT_CNT_BITS'(out_count_reg), OUT_VAL_BITS'(out_word_reg)};

    `ILID_ASSERT(a_count_bound, count_reg <= cnt_t'(DEPTH), "entry count above depth")
    `ILID_ASSERT(a_full_at_depth,
        (out_vld_reg && out_status_reg == ST_FULL) |-> (out_count_reg == cnt_t'(DEPTH)),
        "full status reported below depth")
    `ILID_ASSERT_NEXT(a_append_grows,
        in_vld_reg && adv && in_mode_reg == OP_APPEND && !full,
        count_reg == $past(count_reg) + cnt_t'(1), "append did not grow the list")
    `ILID_ASSERT_NEXT(a_count_steady,
        !(in_vld_reg && adv), $stable(count_reg), "count changed with no operation")

endmodule

>>> sim/tb_indexed_list_insert_delete_top.sv
`timescale 1ns / 1ps
// Self-checking bench for indexed_list_insert_delete_top: directed and random list operations
// on the s_ stream, each result on the m_ stream checked against a predicted list.
// Depends on ilid_pkg and the block's RTL only.
module tb_indexed_list_insert_delete_top;
    import ilid_pkg::*;

    localparam int          RANDOM_OPS  = 1420;
    localparam int unsigned LONG_HOLD   = 120;
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct {
        mode_t       mode;
        logic [4:0]  pos;
        logic [31:0] word;
        int unsigned gap;
        bit          drain;
    } list_op_t;

    typedef struct {
        status_t     status;
        logic [31:0] value;
        logic [4:0]  count;
    } list_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic [1:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic [1:0]             m_tuser;

    list_op_t     op_plan[$];
    list_op_t     next_op;
    list_result_t predicted_results[$];
    list_result_t want;
    list_result_t got;

    // predicted list contents
    word_t       list_words[DEPTH];
    int unsigned list_fill = 0;

    // entry count as seen by the stimulus generator
    int unsigned plan_fill = 0;
    bit          quiet = 1'b0;

    int unsigned tx_idle = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_count = 0;
    int unsigned stall_draw;
    bit          held_off = 1'b0;
    int unsigned results_owed = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;

    indexed_list_insert_delete_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic list_result_t apply_list_op(mode_t mode, logic [4:0] pos,
                                                   logic [31:0] word);
        list_result_t r;
        int unsigned  p;
        r.status = ST_DONE;
        r.value  = '0;
        p        = pos;
        case (mode)
            OP_APPEND: begin
                if (list_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_fill] = word_t'(word);
                    list_fill++;
                end
            end
            OP_INSERT: begin
                if (p > list_fill) begin
                    r.status = ST_RANGE;
                end else if (list_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // open a gap at the target by moving the tail up
                    for (int unsigned i = list_fill; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = word_t'(word);
                    list_fill++;
                end
            end
            OP_DELETE: begin
                if (p >= list_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int unsigned i = p; i + 1 < list_fill; i++)
                        list_words[i] = list_words[i + 1];
                    list_fill--;
                end
            end
            default: begin
                if (p >= list_fill || p >= DEPTH) begin
                    r.status = ST_RANGE;
                end else begin
                    r.value = 32'(list_words[p]);
                end
            end
        endcase
        r.count = 5'(list_fill);
        return r;
    endfunction

    task automatic queue_op(input mode_t mode, input int unsigned pos, input logic [31:0] word,
                            input bit drain);
        list_op_t op;
        op.mode  = mode;
        op.pos   = pos[4:0];
        op.word  = word;
        op.drain = drain;
        op.gap   = quiet ? 0 : $urandom_range(0, 4);
        op_plan.push_back(op);
        // track the count only, so positions can be aimed at the live range
        case (mode)
            OP_APPEND: if (plan_fill < DEPTH) plan_fill++;
            OP_INSERT: if (op.pos <= plan_fill && plan_fill < DEPTH) plan_fill++;
            OP_DELETE: if (op.pos < plan_fill) plan_fill--;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // sender: offer planned operations, idling between them as each one asks
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_idle  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_idle != 0) begin
                s_tvalid <= 1'b0;
                tx_idle  <= tx_idle - 1;
            end else if (op_plan.size() != 0 &&
                         !(op_plan[0].drain && (s_tvalid || results_owed != 0))) begin
                next_op = op_plan.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.mode;
                s_tdata  <= {{(S_DATA_BITS - IN_VAL_BITS - IN_POS_BITS){1'b0}},
                             next_op.word, next_op.pos};
                tx_idle  <= next_op.gap;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
            rx_hold  <= 0;
            rx_count <= 0;
            held_off <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                rx_count <= rx_count + 1;
            if (rx_hold != 0) begin
                m_tready <= 1'b0;
                rx_hold  <= rx_hold - 1;
            end else if (!held_off && rx_count >= 300) begin
                held_off <= 1'b1;
                rx_hold  <= LONG_HOLD;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                stall_draw = (rx_count % 256 < 64) ? 0 : $urandom_range(0, 4);
                m_tready <= (stall_draw == 0);
                rx_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
            end else if (rx_stall != 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            results_owed <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.value  = m_tdata[OUT_VAL_BITS-1:0];
                got.count  = m_tdata[OUT_VAL_BITS +: OUT_CNT_BITS];
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: status %0d value %h count %0d",
                             $time, got.status, got.value, got.count);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.value !== want.value) begin
                        mismatches++;
                        $display("%0t: value_out mismatch: expected %h, actual %h",
                                 $time, want.value, got.value);
                    end
                    if (got.count !== want.count) begin
                        mismatches++;
                        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, got.count);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(apply_list_op(s_tuser,
                    s_tdata[IN_POS_BITS-1:0], s_tdata[IN_POS_BITS +: IN_VAL_BITS]));
            results_owed <= results_owed + (s_tvalid && s_tready) - (m_tvalid && m_tready);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("indexed_list_insert_delete_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned pos;
        mode_t       mode;
        bit          growing;

        // empty list: read, delete and insert past the count are out of range; insert at 0 works
        queue_op(OP_READ,   0,  32'h0, 1'b0);
        queue_op(OP_DELETE, 0,  32'h0, 1'b0);
        queue_op(OP_INSERT, 1,  32'h0, 1'b0);
        queue_op(OP_INSERT, 0,  32'h7fff_ffff, 1'b0);
        queue_op(OP_APPEND, 31, 32'h8000_0000, 1'b0);
        queue_op(OP_INSERT, 1,  32'hffff_ffff, 1'b0);
        // insert at the count lands at the end
        queue_op(OP_INSERT, 3,  32'h0000_0000, 1'b0);
        queue_op(OP_READ,   0,  32'h0, 1'b0);
        queue_op(OP_READ,   3,  32'h0, 1'b0);
        queue_op(OP_READ,   4,  32'h0, 1'b0);
        queue_op(OP_DELETE, 0,  32'h0, 1'b0);
        queue_op(OP_DELETE, 2,  32'h0, 1'b0);
        queue_op(OP_READ,   1,  32'h0, 1'b0);
        // fill up with a mix of inserts and appends
        while (plan_fill < DEPTH) begin
            if (plan_fill % 2 == 0)
                queue_op(OP_INSERT, $urandom_range(0, plan_fill), random_word(), 1'b0);
            else
                queue_op(OP_APPEND, 0, random_word(), 1'b0);
        end
        queue_op(OP_APPEND, 0,  32'h1234_5678, 1'b0);
        queue_op(OP_INSERT, 5,  32'h1234_5678, 1'b0);
        // bad position wins over full
        queue_op(OP_INSERT, 17, 32'h1234_5678, 1'b0);
        queue_op(OP_READ,   15, 32'h0, 1'b0);
        queue_op(OP_READ,   16, 32'h0, 1'b0);
        queue_op(OP_READ,   31, 32'h0, 1'b0);
        queue_op(OP_DELETE, 15, 32'h0, 1'b0);
        queue_op(OP_DELETE, 16, 32'h0, 1'b0);

        growing = 1'b0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            quiet = (n % 300) < 40;
            if (plan_fill >= DEPTH)
                growing = 1'b0;
            else if (plan_fill == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
            pick = $urandom_range(0, 99);
            if (growing)
                mode = (pick < 30) ? OP_APPEND : (pick < 60) ? OP_INSERT :
                       (pick < 75) ? OP_DELETE : OP_READ;
            else
                mode = (pick < 10) ? OP_APPEND : (pick < 25) ? OP_INSERT :
                       (pick < 70) ? OP_DELETE : OP_READ;
            // mostly aim inside the live range, sometimes anywhere
            if ($urandom_range(0, 9) == 0 || mode == OP_APPEND)
                pos = $urandom_range(0, 31);
            else if (mode == OP_INSERT)
                pos = $urandom_range(0, plan_fill);
            else if (plan_fill == 0)
                pos = $urandom_range(0, 2);
            else
                pos = $urandom_range(0, plan_fill - 1);
            queue_op(mode, pos, random_word(), n == 700 || $urandom_range(0, 99) == 0);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // hold until every operation is sent and answered
        do
            @(negedge aclk);
        while (op_plan.size() != 0 || s_tvalid || results_owed != 0);
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("indexed_list_insert_delete_top test passed");
        else
            $display("indexed_list_insert_delete_top test failed");
        $finish;
    end

endmodule
